// File: src/cascaded_quaternion_nlerp_filter_macros.svh
// Assertion macros for the quaternion nlerp filter RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CASCADED_QUATERNION_NLERP_FILTER_MACROS_SVH
`define CASCADED_QUATERNION_NLERP_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define CQNF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CQNF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CQNF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CQNF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: src/cqnf_pkg.sv
// Shared constants, types and helpers of the quaternion nlerp filter.
// No dependencies; imported by every other file but the macros header.
package cqnf_pkg;

  localparam int STAGES     = 3;
  localparam int COMP_WIDTH = 16;
  localparam int FIELD_W    = 16;
  localparam int CFG_W      = 17;
  localparam int STG_W      = (STAGES > 1) ? $clog2(STAGES) : 1;

  localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(65536);
  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;
  localparam logic signed [33:0] COMP_MAX = (34'sd1 <<< (COMP_WIDTH - 1)) - 34'sd1;

  typedef logic signed [FIELD_W-1:0]    field_t;
  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_ALL,
    OP_SEL,
    OP_CLR,
    OP_MUL_DOT,
    OP_ACC,
    OP_MUL_RA,
    OP_MUL_RB,
    OP_ADD_R,
    OP_SHR,
    OP_SHL,
    OP_ZERO,
    OP_MUL_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_STORE
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [1:0]       idx;
    logic [STG_W-1:0] stage;
    logic             to_out;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic m_hi;
    logic m_lo;
  } dp_sts_t;

  // Clamp to the symmetric stored range.
  function automatic comp_t comp_sat(input logic signed [17:0] v);
    logic signed [33:0] w;
    w = 34'(v);
    if (w > COMP_MAX) return COMP_WIDTH'(COMP_MAX);
    if (w < -COMP_MAX) return COMP_WIDTH'(-COMP_MAX);
    return COMP_WIDTH'(w);
  endfunction

endpackage

// File: src/cqnf_in_if.sv
// Input channel: valid/ready handshake with request type and quaternion.
// Depends on cqnf_pkg.
interface cqnf_in_if;
  import cqnf_pkg::*;
  logic   valid;
  logic   ready;
  logic   req_type;
  field_t in_w;
  field_t in_x;
  field_t in_y;
  field_t in_z;
  modport source (output valid, req_type, in_w, in_x, in_y, in_z, input ready);
  modport sink   (input valid, req_type, in_w, in_x, in_y, in_z, output ready);
endinterface

// File: src/cqnf_out_if.sv
// Output channel: valid/ready handshake carrying the filtered quaternion.
// Depends on cqnf_pkg.
interface cqnf_out_if;
  import cqnf_pkg::*;
  logic   valid;
  logic   ready;
  field_t out_w;
  field_t out_x;
  field_t out_y;
  field_t out_z;
  modport source (output valid, out_w, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

// File: src/cqnf_cfg_if.sv
// Configuration write channel: valid/ready with the coefficient word.
// Depends on cqnf_pkg.
interface cqnf_cfg_if;
  import cqnf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: src/cascaded_quaternion_nlerp_filter.sv
// Cascaded quaternion nlerp low-pass filter, top level.
// Joins cqnf_ctrl and cqnf_datapath to the channel interfaces; uses cqnf_pkg.
//
// Use: an input word (in_i) carries req_type and a Q1.14 quaternion. req_type 0
// runs the quaternion through three smoothing stages; each stage blends its stored
// attitude toward its input by the coefficient, takes the shorter arc, and
// renormalises. req_type 1 loads the quaternion into every stage and echoes it.
// Each input word gives exactly one output word (out_o) with the last stage.
// The coefficient (unsigned Q1.16, 65536 = 1.0, larger values act as 1.0) is
// written on cfg_i, which is always ready; write it only while the block idles.
// A filter word walks each stage through dot product, blend, normalising shifts,
// square root and a divide per component; a stage whose blend has zero length
// skips the square root and the divides. The single shared multiplier, the
// one-bit-a-cycle square root and the one-bit-a-cycle divider set the pace.
// One word is in work at a time; the next is taken as soon as the sequencer is
// idle again.
// The output word sits in a register: a stalled receiver does not block the
// next input, but the finished next result waits until that register is free.
// Reset puts the identity quaternion in every stage and the coefficient at 1.0.
module cascaded_quaternion_nlerp_filter (
  input logic         clk_i,
  input logic         rst_ni,
  cqnf_in_if.sink     in_i,
  cqnf_out_if.source  out_o,
  cqnf_cfg_if.sink    cfg_i
);
  import cqnf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration never stalls
  assign cfg_i.ready = 1'b1;

  cqnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_load_i   (in_i.req_type),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cqnf_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .in_w_i     (in_i.in_w),
    .in_x_i     (in_i.in_x),
    .in_y_i     (in_i.in_y),
    .in_z_i     (in_i.in_z),
    .out_w_o    (out_o.out_w),
    .out_x_o    (out_o.out_x),
    .out_y_o    (out_o.out_y),
    .out_z_o    (out_o.out_z)
  );

endmodule

// File: src/cqnf_datapath.sv
// Arithmetic of the filter: stage store, shared multiplier, normaliser,
// bit-serial square root and divider. Driven by cqnf_ctrl; uses cqnf_pkg.
module cqnf_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cqnf_pkg::dp_cmd_t          cmd_i,
  output cqnf_pkg::dp_sts_t          sts_o,
  input  logic                       cfg_we_i,
  input  logic [cqnf_pkg::CFG_W-1:0] cfg_data_i,
  input  cqnf_pkg::field_t           in_w_i,
  input  cqnf_pkg::field_t           in_x_i,
  input  cqnf_pkg::field_t           in_y_i,
  input  cqnf_pkg::field_t           in_z_i,
  output cqnf_pkg::field_t           out_w_o,
  output cqnf_pkg::field_t           out_x_o,
  output cqnf_pkg::field_t           out_y_o,
  output cqnf_pkg::field_t           out_z_o
);
  import cqnf_pkg::*;

  comp_t              stage_q [STAGES][4];
  logic [CFG_W-1:0]   c_q;
  field_t             a_q [4];
  field_t             b_q [4];
  field_t             out_q [4];
  comp_t              w_q [4];
  logic signed [63:0] p_q;
  logic signed [63:0] acc_q;
  logic signed [33:0] r_q [4];
  logic [31:0]        mag_q [4];
  logic [62:0]        res_q;
  logic [62:0]        bit_q;
  logic [46:0]        rem_q;
  logic [46:0]        ds_q;
  logic [15:0]        quo_q;

  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] prod;
  logic [31:0]        m01;
  logic [31:0]        m23;
  logic [31:0]        m_max;
  logic signed [33:0] p34;
  logic signed [33:0] rsum;
  logic [31:0]        rabs;
  logic [62:0]        trial;
  logic [31:0]        n_eff;
  logic signed [17:0] qs;
  logic signed [17:0] qv;
  logic [1:0]         i;

  assign i = cmd_i.idx;

  // Shared multiplier: operand selection by command
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.op)
      OP_MUL_DOT: begin
        opa = 32'(a_q[i]);
        opb = 32'(b_q[i]);
      end
      OP_MUL_RA: begin
        opa = 32'(a_q[i]);
        opb = $signed({15'b0, COEF_ONE - c_q});
      end
      OP_MUL_RB: begin
        opa = 32'(b_q[i]);
        opb = $signed({15'b0, c_q});
      end
      OP_MUL_SQ: begin
        opa = $signed({1'b0, mag_q[i][30:0]});
        opb = $signed({1'b0, mag_q[i][30:0]});
      end
      default: ;
    endcase
  end

  assign prod = opa * opb;

  // Largest magnitude drives the normaliser
  assign m01   = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
  assign m23   = (mag_q[2] > mag_q[3]) ? mag_q[2] : mag_q[3];
  assign m_max = (m01 > m23) ? m01 : m23;

  assign sts_o.m_zero = (m_max == '0);
  assign sts_o.m_hi   = (m_max[31:30] != 2'b00);
  assign sts_o.m_lo   = (m_max[31:29] == 3'b000);

  // Sign of the dot product sits in the accumulator until squares start
  assign p34   = p_q[33:0];
  assign rsum  = r_q[i] + (acc_q[63] ? -p34 : p34);
  assign rabs  = rsum[33] ? 32'(-rsum) : 32'(rsum);
  assign trial = res_q + bit_q;
  assign n_eff = (res_q == '0) ? 32'd1 : res_q[31:0];
  assign qs    = $signed({2'b00, quo_q});
  assign qv    = r_q[i][33] ? -qs : qs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= COEF_ONE;
    end else if (cfg_we_i) begin
      c_q <= (cfg_data_i > COEF_ONE) ? COEF_ONE : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        stage_q[k][0] <= comp_sat(ONE_Q14);
        stage_q[k][1] <= '0;
        stage_q[k][2] <= '0;
        stage_q[k][3] <= '0;
      end
    end else if (cmd_i.op == OP_LOAD_ALL) begin
      for (int k = 0; k < STAGES; k++) begin
        for (int j = 0; j < 4; j++) stage_q[k][j] <= comp_sat(18'(b_q[j]));
      end
    end else if (cmd_i.op == OP_STORE) begin
      for (int j = 0; j < 4; j++) stage_q[cmd_i.stage][j] <= w_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        b_q[0] <= in_w_i;
        b_q[1] <= in_x_i;
        b_q[2] <= in_y_i;
        b_q[3] <= in_z_i;
      end
      OP_LOAD_ALL: begin
        for (int j = 0; j < 4; j++) out_q[j] <= FIELD_W'(comp_sat(18'(b_q[j])));
      end
      OP_SEL: begin
        for (int j = 0; j < 4; j++) a_q[j] <= FIELD_W'(stage_q[cmd_i.stage][j]);
        acc_q <= '0;
      end
      OP_CLR: acc_q <= '0;
      OP_MUL_DOT, OP_MUL_RA, OP_MUL_SQ: p_q <= prod;
      OP_MUL_RB: begin
        r_q[i] <= p34;
        p_q    <= prod;
      end
      OP_ACC: acc_q <= acc_q + p_q;
      OP_ADD_R: begin
        r_q[i]   <= rsum;
        mag_q[i] <= rabs;
      end
      OP_SHR: for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] >> 1;
      OP_SHL: for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] << 1;
      OP_ZERO: for (int j = 0; j < 4; j++) w_q[j] <= '0;
      OP_SQRT_INIT: begin
        res_q <= '0;
        bit_q <= 63'(1) << 62;
      end
      OP_SQRT_STEP: begin
        if (acc_q[62:0] >= trial) begin
          acc_q <= $signed({1'b0, acc_q[62:0] - trial});
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        rem_q <= {2'b00, mag_q[i][29:0], 15'b0} + 47'(n_eff);
        ds_q  <= 47'({n_eff, 16'b0});
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_q >= ds_q) begin
          rem_q <= rem_q - ds_q;
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          quo_q <= {quo_q[14:0], 1'b0};
        end
        ds_q <= ds_q >> 1;
      end
      OP_DIV_END: w_q[i] <= comp_sat(qv);
      OP_STORE: begin
        for (int j = 0; j < 4; j++) begin
          b_q[j] <= FIELD_W'(w_q[j]);
          if (cmd_i.to_out) out_q[j] <= FIELD_W'(w_q[j]);
        end
      end
      default: ;
    endcase
  end

  assign out_w_o = out_q[0];
  assign out_x_o = out_q[1];
  assign out_y_o = out_q[2];
  assign out_z_o = out_q[3];

endmodule

// File: src/cqnf_ctrl.sv
// Sequencer of the filter: walks each stage through dot, blend, normalise,
// root and divide, and owns the handshakes. Uses cqnf_pkg and the macros.
`include "cascaded_quaternion_nlerp_filter_macros.svh"

module cqnf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_load_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cqnf_pkg::dp_sts_t sts_i,
  output cqnf_pkg::dp_cmd_t cmd_o
);
  import cqnf_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_SEL    = 5'd2;
  localparam logic [4:0] S_DOT_M  = 5'd3;
  localparam logic [4:0] S_DOT_A  = 5'd4;
  localparam logic [4:0] S_R_A    = 5'd5;
  localparam logic [4:0] S_R_B    = 5'd6;
  localparam logic [4:0] S_R_C    = 5'd7;
  localparam logic [4:0] S_NORM   = 5'd8;
  localparam logic [4:0] S_SQ_M   = 5'd9;
  localparam logic [4:0] S_SQ_A   = 5'd10;
  localparam logic [4:0] S_SQRT_I = 5'd11;
  localparam logic [4:0] S_SQRT   = 5'd12;
  localparam logic [4:0] S_DIV_I  = 5'd13;
  localparam logic [4:0] S_DIV    = 5'd14;
  localparam logic [4:0] S_DIV_E  = 5'd15;
  localparam logic [4:0] S_STORE  = 5'd16;

  localparam logic [STG_W-1:0] LAST_STG = STG_W'(STAGES - 1);

  logic [4:0]       state_q, state_d;
  logic [1:0]       idx_q, idx_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [STG_W-1:0] stg_q, stg_d;
  logic             out_valid_q, out_valid_d;
  logic             out_busy;
  logic             out_set;

  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    stg_d      = stg_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = idx_q;
    cmd_o.stage = stg_q;
    cmd_o.to_out = (stg_q == LAST_STG);
    in_ready_o = (state_q == S_IDLE);
    out_set    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          stg_d    = '0;
          state_d  = in_load_i ? S_LOAD : S_SEL;
        end
      end
      S_LOAD: begin
        // hold until the output word is free
        if (!out_busy) begin
          cmd_o.op = OP_LOAD_ALL;
          out_set  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SEL: begin
        cmd_o.op = OP_SEL;
        idx_d    = '0;
        state_d  = S_DOT_M;
      end
      S_DOT_M: begin
        cmd_o.op = OP_MUL_DOT;
        state_d  = S_DOT_A;
      end
      S_DOT_A: begin
        cmd_o.op = OP_ACC;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == 2'd3) ? S_R_A : S_DOT_M;
      end
      S_R_A: begin
        cmd_o.op = OP_MUL_RA;
        state_d  = S_R_B;
      end
      S_R_B: begin
        cmd_o.op = OP_MUL_RB;
        state_d  = S_R_C;
      end
      S_R_C: begin
        cmd_o.op = OP_ADD_R;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == 2'd3) ? S_NORM : S_R_A;
      end
      S_NORM: begin
        if (sts_i.m_zero) begin
          cmd_o.op = OP_ZERO;
          state_d  = S_STORE;
        end else if (sts_i.m_hi) begin
          cmd_o.op = OP_SHR;
        end else if (sts_i.m_lo) begin
          cmd_o.op = OP_SHL;
        end else begin
          cmd_o.op = OP_CLR;
          idx_d    = '0;
          state_d  = S_SQ_M;
        end
      end
      S_SQ_M: begin
        cmd_o.op = OP_MUL_SQ;
        state_d  = S_SQ_A;
      end
      S_SQ_A: begin
        cmd_o.op = OP_ACC;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == 2'd3) ? S_SQRT_I : S_SQ_M;
      end
      S_SQRT_I: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          idx_d   = '0;
          state_d = S_DIV_I;
        end
      end
      S_DIV_I: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd15) state_d = S_DIV_E;
      end
      S_DIV_E: begin
        cmd_o.op = OP_DIV_END;
        idx_d    = idx_q + 2'd1;
        state_d  = (idx_q == 2'd3) ? S_STORE : S_DIV_I;
      end
      S_STORE: begin
        if (stg_q == LAST_STG) begin
          if (!out_busy) begin
            cmd_o.op = OP_STORE;
            out_set  = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_STORE;
          stg_d    = stg_q + STG_W'(1);
          state_d  = S_SEL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_set) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      stg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      stg_q       <= stg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `CQNF_ASSERT_IMP(a_result_not_overwritten, clk_i, rst_ni, out_set, !out_valid_q || out_ready_i, "result word overwritten before it was taken")
  `CQNF_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, state_q == S_IDLE && in_valid_i, state_q != S_IDLE, "accepted word did not start work")
  `CQNF_ASSERT_IMP(a_div_end_after_steps, clk_i, rst_ni, state_q == S_DIV_E, $past(state_q) == S_DIV && $past(cnt_q) == 5'd15, "division ended early")

endmodule
